/* design/tccs_pkg.sv */
// Shared types and constants for the text console cursor and scroll engine.
package tccs_pkg;

  typedef enum logic [2:0] {
    MODE_PUT        = 3'd0,
    MODE_SET_CURSOR = 3'd1,
    MODE_CLEAR      = 3'd2,
    MODE_SET_COLORS = 3'd3,
    MODE_READ       = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_SC_PRIME,
    ST_SC_COPY,
    ST_SC_FILL,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_FIRST     = 8'd32;
  localparam logic [7:0] CH_DELETE    = 8'd127;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h07;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture input beat
    logic addr;    // compute cell address
    logic exec;    // apply the item's cursor/attribute update and single write
    logic rd_src;  // read port follows the sweep pointer (scroll source)
    logic copy;    // write previous read data at pointer, advance
    logic fill;    // write blank at pointer, advance
    logic emit;    // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scroll;
    logic do_clear;
    logic no_copy;
    logic copy_end;
    logic work_end;
    logic cells_end;
    logic out_stall;
  } stat_t;

endpackage

/* design/tccs_ctrl.sv */
// Sequencer for item handling, scroll sweep and screen clear sweep.
module tccs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output tccs_pkg::cmd_t cmd,
  input  tccs_pkg::stat_t stat
);
  import tccs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.fill = 1'b1;
        if (stat.cells_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.do_clear) begin
          state_next = ST_CLEAR;
        end else if (stat.need_scroll) begin
          state_next = stat.no_copy ? ST_SC_FILL : ST_SC_PRIME;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SC_PRIME: begin
        // first source row read, nothing to write yet
        cmd.rd_src = 1'b1;
        state_next = ST_SC_COPY;
      end
      ST_SC_COPY: begin
        cmd.rd_src = 1'b1;
        cmd.copy   = 1'b1;
        if (stat.copy_end) state_next = ST_SC_FILL;
      end
      ST_SC_FILL: begin
        cmd.fill = 1'b1;
        if (stat.work_end) state_next = ST_RESULT;
      end
      ST_CLEAR: begin
        cmd.fill = 1'b1;
        if (stat.cells_end) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!stat.out_stall) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* design/tccs_dp.sv */
// Datapath: cursor, attribute, screen memory, sweep pointer and result register.
module tccs_dp #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int WORK_ROWS = 24,
  parameter int TAB_STEP  = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  tccs_pkg::cmd_t  cmd,
  output tccs_pkg::stat_t stat,
  input  logic [2:0]      mode,
  input  logic [7:0]      character,
  input  logic [7:0]      row,
  input  logic [7:0]      column,
  input  logic [3:0]      foreground,
  input  logic [3:0]      background,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [4:0]      cursor_row,
  output logic [6:0]      cursor_column,
  output logic [10:0]     cursor_position,
  output logic [15:0]     cell_value
);
  import tccs_pkg::*;

  localparam int WORK_EFF = (WORK_ROWS < ROWS) ? WORK_ROWS : ROWS;
  localparam int CELLS    = ROWS * COLUMNS;
  localparam int COPY     = (WORK_EFF - 1) * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int RW       = $clog2(ROWS);
  localparam int CW       = $clog2(COLUMNS);
  localparam int TW       = $clog2(COLUMNS + TAB_STEP);
  localparam logic [RW-1:0] LAST_WORK_ROW = RW'(WORK_EFF - 1);
  localparam logic [AW-1:0] CELLS_LAST    = AW'(CELLS - 1);
  localparam logic [AW-1:0] WORK_LAST     = AW'(WORK_EFF * COLUMNS - 1);
  localparam logic [AW-1:0] COPY_LAST     = AW'(COPY - 1);

  logic [15:0] mem [CELLS];

  logic [2:0]    mode_q;
  logic [7:0]    char_q, row_q, col_q;
  logic [3:0]    fg_q, bg_q;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [7:0]    attr, attr_next;
  logic [AW-1:0] addr_reg;
  logic [AW-1:0] ptr;
  logic [15:0]   rd_data;

  logic          target_ok;
  logic          rd_ok;
  logic          advance;
  logic          need_scroll;
  logic          do_clear;
  logic          put_wr;
  logic          put_back;
  logic [RW:0]   row_inc;
  logic [CW:0]   col_inc;
  logic [TW-1:0] tab_sum;
  logic [7:0]    sel_r, sel_c;
  logic [31:0]   addr_wide;
  logic [31:0]   rd_wide;
  logic [31:0]   pos_wide;
  logic [31:0]   row_ext, col_ext;
  logic [AW-1:0] raddr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  // Input beat capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      char_q <= character;
      row_q  <= row;
      col_q  <= column;
      fg_q   <= foreground;
      bg_q   <= background;
    end
  end

  assign target_ok = (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS);
  assign rd_ok     = (mode_q == MODE_READ) && target_ok;

  // Cell address of the read target or of the cursor
  always_comb begin
    if (mode_q == MODE_READ) begin
      sel_r = row_q;
      sel_c = col_q;
    end else begin
      sel_r = 8'(cur_row);
      sel_c = 8'(cur_col);
    end
    addr_wide = 32'(sel_r) * COLUMNS + 32'(sel_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.addr) addr_reg <= addr_wide[AW-1:0];
  end

  // Per-item cursor and attribute update
  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    attr_next    = attr;
    advance      = 1'b0;
    need_scroll  = 1'b0;
    do_clear     = 1'b0;
    put_wr       = 1'b0;
    put_back     = 1'b0;
    row_inc      = (RW+1)'(cur_row) + 1'b1;
    col_inc      = (CW+1)'(cur_col) + 1'b1;
    tab_sum      = TW'(cur_col) + TW'(TAB_STEP);
    unique case (mode_q)
      MODE_PUT: begin
        unique case (char_q)
          CH_NEWLINE: advance = 1'b1;
          CH_TAB: begin
            if (32'(tab_sum) >= COLUMNS) advance = 1'b1;
            else cur_col_next = CW'(tab_sum);
          end
          CH_BACKSPACE: begin
            if (cur_col != '0) begin
              cur_col_next = cur_col - 1'b1;
              put_back     = 1'b1;
            end
          end
          default: begin
            if (char_q >= CH_FIRST && char_q < CH_DELETE) begin
              put_wr = 1'b1;
              if (32'(col_inc) >= COLUMNS) advance = 1'b1;
              else cur_col_next = CW'(col_inc);
            end
          end
        endcase
        if (advance) begin
          cur_col_next = '0;
          if (32'(row_inc) >= WORK_EFF) begin
            cur_row_next = LAST_WORK_ROW;
            need_scroll  = 1'b1;
          end else begin
            cur_row_next = RW'(row_inc);
          end
        end
      end
      MODE_SET_CURSOR: begin
        if (target_ok) begin
          cur_row_next = RW'(row_q);
          cur_col_next = CW'(col_q);
        end
      end
      MODE_CLEAR: begin
        attr_next    = {bg_q, DEFAULT_ATTR[3:0]};
        cur_row_next = '0;
        cur_col_next = '0;
        do_clear     = 1'b1;
      end
      MODE_SET_COLORS: attr_next = {bg_q, fg_q};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      attr    <= DEFAULT_ATTR;
      ptr     <= '0;
    end else begin
      if (cmd.exec) begin
        cur_row <= cur_row_next;
        cur_col <= cur_col_next;
        attr    <= attr_next;
        ptr     <= '0;
      end else if (cmd.copy || cmd.fill) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // Read port: item address, or scroll source one row below the pointer (one cell ahead while copying)
  always_comb begin
    rd_wide = 32'(ptr) + 32'(COLUMNS) + (cmd.copy ? 32'd1 : 32'd0);
    raddr   = cmd.rd_src ? rd_wide[AW-1:0] : addr_reg;
  end

  // Write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = {attr, BLANK_CHAR};
    if (cmd.copy) begin
      wr_en   = 1'b1;
      wr_data = rd_data;
    end else if (cmd.fill) begin
      wr_en = 1'b1;
    end else if (cmd.exec && put_wr) begin
      wr_en   = 1'b1;
      wr_addr = addr_reg;
      wr_data = {attr, char_q};
    end else if (cmd.exec && put_back) begin
      wr_en   = 1'b1;
      wr_addr = addr_reg - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[raddr];
  end

  // Result register
  assign row_ext  = 32'(cur_row);
  assign col_ext  = 32'(cur_col);
  assign pos_wide = row_ext * COLUMNS + col_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cursor_row      <= row_ext[4:0];
      cursor_column   <= col_ext[6:0];
      cursor_position <= pos_wide[10:0];
      cell_value      <= rd_ok ? rd_data : 16'h0000;
    end
  end

  assign stat.need_scroll = need_scroll;
  assign stat.do_clear    = do_clear;
  assign stat.no_copy     = (COPY == 0);
  assign stat.copy_end    = (ptr == COPY_LAST);
  assign stat.work_end    = (ptr == WORK_LAST);
  assign stat.cells_end   = (ptr == CELLS_LAST);
  assign stat.out_stall   = out_valid && !out_ready;

endmodule

/* design/text_console_cursor_scroll.sv */
// Plain items (put char without scroll, set cursor, set colors, read) step from accept
// through the address, execute and result states; out_valid is registered on leaving result.
// A scroll adds a prime step and a sweep over the work rows, a clear a sweep over all cells;
// each sweep over screen memory covers one cell per cycle.
// Reset zeroes the cursor, sets the attribute to light grey on black, then sweeps
// all ROWS*COLUMNS cells, writing blank grey cells; in_ready stays low
// until the sweep ends.
module text_console_cursor_scroll #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int WORK_ROWS = 24,
  parameter int TAB_STEP  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [7:0]  character,
  input  logic [7:0]  row,
  input  logic [7:0]  column,
  input  logic [3:0]  foreground,
  input  logic [3:0]  background,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_column,
  output logic [10:0] cursor_position,
  output logic [15:0] cell_value
);
  import tccs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tccs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tccs_dp #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .WORK_ROWS (WORK_ROWS),
    .TAB_STEP  (TAB_STEP)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .mode            (mode),
    .character       (character),
    .row             (row),
    .column          (column),
    .foreground      (foreground),
    .background      (background),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_row      (cursor_row),
    .cursor_column   (cursor_column),
    .cursor_position (cursor_position),
    .cell_value      (cell_value)
  );

endmodule

/* dv/console_checker.sv */
// Shadow console model and cursor report checking for the text console engine.
module console_checker
  import tccs_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int WORK_ROWS = 24,
  parameter int TAB_STEP  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [7:0]  character,
  input  logic [7:0]  row,
  input  logic [7:0]  column,
  input  logic [3:0]  foreground,
  input  logic [3:0]  background,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  cursor_row,
  input  logic [6:0]  cursor_column,
  input  logic [10:0] cursor_position,
  input  logic [15:0] cell_value,
  output int          mismatch_count,
  output int          reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORK_HEIGHT = (WORK_ROWS < ROWS) ? WORK_ROWS : ROWS;
  localparam int CELLS       = ROWS * COLUMNS;

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  column;
    logic [10:0] position;
    logic [15:0] cell_word;
  } cursor_report_t;

  logic [15:0]    shadow_screen [CELLS];
  int             shadow_row;
  int             shadow_col;
  logic [7:0]     shadow_attr;
  cursor_report_t cursor_reports_q [$];

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) begin
      shadow_screen[i] = {shadow_attr, BLANK_CHAR};
    end
  endfunction

  // Shift the work rows up; status rows below them stay put.
  function automatic void scroll_work_rows();
    for (int r = 0; r + 1 < WORK_HEIGHT; r++) begin
      for (int c = 0; c < COLUMNS; c++) begin
        shadow_screen[r * COLUMNS + c] = shadow_screen[(r + 1) * COLUMNS + c];
      end
    end
    for (int c = 0; c < COLUMNS; c++) begin
      shadow_screen[(WORK_HEIGHT - 1) * COLUMNS + c] = {shadow_attr, BLANK_CHAR};
    end
    shadow_row = WORK_HEIGHT - 1;
  endfunction

  function automatic void advance_row();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= WORK_HEIGHT) begin
      scroll_work_rows();
    end
  endfunction

  function automatic void place_char(input logic [7:0] ch);
    if (ch == CH_NEWLINE) begin
      advance_row();
    end else if (ch == CH_TAB) begin
      shadow_col += TAB_STEP;
      if (shadow_col >= COLUMNS) begin
        advance_row();
      end
    end else if (ch == CH_BACKSPACE) begin
      if (shadow_col > 0) begin
        shadow_col--;
        shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, BLANK_CHAR};
      end
    end else if (ch >= CH_FIRST && ch < CH_DELETE) begin
      shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, ch};
      shadow_col++;
      if (shadow_col >= COLUMNS) begin
        advance_row();
      end
    end
  endfunction

  function automatic cursor_report_t apply_console_item(
    input logic [2:0] m,
    input logic [7:0] ch,
    input logic [7:0] r,
    input logic [7:0] c,
    input logic [3:0] fg,
    input logic [3:0] bg
  );
    cursor_report_t rep;
    logic [15:0]    read_word;
    int             position;
    read_word = '0;
    case (m)
      MODE_PUT: begin
        place_char(ch);
      end
      MODE_SET_CURSOR: begin
        if (r < ROWS && c < COLUMNS) begin
          shadow_row = r;
          shadow_col = c;
        end
      end
      MODE_CLEAR: begin
        shadow_attr = DEFAULT_ATTR | {bg, 4'h0};
        blank_screen();
        shadow_row = 0;
        shadow_col = 0;
      end
      MODE_SET_COLORS: begin
        shadow_attr = {bg, fg};
      end
      MODE_READ: begin
        if (r < ROWS && c < COLUMNS) begin
          read_word = shadow_screen[r * COLUMNS + c];
        end
      end
      default: ;
    endcase
    position      = shadow_row * COLUMNS + shadow_col;
    rep.row       = shadow_row[4:0];
    rep.column    = shadow_col[6:0];
    rep.position  = position[10:0];
    rep.cell_word = read_word;
    return rep;
  endfunction

  always @(posedge clk) begin
    cursor_report_t exp_rep;
    cursor_report_t got_rep;
    if (rst) begin
      shadow_attr = DEFAULT_ATTR;
      blank_screen();
      shadow_row = 0;
      shadow_col = 0;
      cursor_reports_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        cursor_reports_q.push_back(
          apply_console_item(mode, character, row, column, foreground, background));
      end
      if (out_valid && out_ready) begin
        got_rep = '{cursor_row, cursor_column, cursor_position, cell_value};
        if (cursor_reports_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result beat row %0d col %0d pos %0d cell %h",
                     $realtime, got_rep.row, got_rep.column, got_rep.position,
                     got_rep.cell_word);
          end
        end else begin
          exp_rep = cursor_reports_q.pop_front();
          if (got_rep.row !== exp_rep.row || got_rep.column !== exp_rep.column ||
              got_rep.position !== exp_rep.position ||
              got_rep.cell_word !== exp_rep.cell_word) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch (exp/got) row %0d/%0d col %0d/%0d",
                       $realtime, exp_rep.row, got_rep.row, exp_rep.column,
                       got_rep.column);
              $display("  pos %0d/%0d cell %h/%h", exp_rep.position, got_rep.position,
                       exp_rep.cell_word, got_rep.cell_word);
            end
          end
        end
      end
    end
    reports_due = cursor_reports_q.size();
  end

endmodule

/* dv/testbench.sv */
// Top of the console engine testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tccs_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int WORK_ROWS    = 24;
  localparam int TAB_STEP     = 4;
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 750;
  localparam int PHASES       = 5;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  mode;
  logic [7:0]  character;
  logic [7:0]  row;
  logic [7:0]  column;
  logic [3:0]  foreground;
  logic [3:0]  background;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_column;
  logic [10:0] cursor_position;
  logic [15:0] cell_value;
  int          mismatch_count;
  int          reports_due;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;

  text_console_cursor_scroll #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .WORK_ROWS(WORK_ROWS),
    .TAB_STEP (TAB_STEP)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .character      (character),
    .row            (row),
    .column         (column),
    .foreground     (foreground),
    .background     (background),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_row     (cursor_row),
    .cursor_column  (cursor_column),
    .cursor_position(cursor_position),
    .cell_value     (cell_value)
  );

  console_checker #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .WORK_ROWS(WORK_ROWS),
    .TAB_STEP (TAB_STEP)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .character      (character),
    .row            (row),
    .column         (column),
    .foreground     (foreground),
    .background     (background),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_row     (cursor_row),
    .cursor_column  (cursor_column),
    .cursor_position(cursor_position),
    .cell_value     (cell_value),
    .mismatch_count (mismatch_count),
    .reports_due    (reports_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: stall a random number of cycles, then take one beat.
  initial begin
    int stall;
    out_ready <= 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(
    input logic [2:0] m,
    input logic [7:0] ch,
    input logic [7:0] r,
    input logic [7:0] c,
    input logic [3:0] fg,
    input logic [3:0] bg
  );
    int gap;
    gap = no_idle ? 0 : $urandom_range(3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    character  <= ch;
    row        <= r;
    column     <= c;
    foreground <= fg;
    background <= bg;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_item();
    int         pick;
    logic [7:0] ch;
    logic [7:0] r;
    logic [7:0] c;
    logic [3:0] fg;
    logic [3:0] bg;
    pick = $urandom_range(99);
    ch   = 8'($urandom);
    r    = 8'($urandom);
    c    = 8'($urandom);
    fg   = 4'($urandom);
    bg   = 4'($urandom);
    if (pick < 40) begin
      send_item(MODE_PUT, 8'($urandom_range(CH_DELETE - 1, CH_FIRST)), r, c, fg, bg);
    end else if (pick < 48) begin
      send_item(MODE_PUT, CH_NEWLINE, r, c, fg, bg);
    end else if (pick < 55) begin
      send_item(MODE_PUT, CH_TAB, r, c, fg, bg);
    end else if (pick < 62) begin
      send_item(MODE_PUT, CH_BACKSPACE, r, c, fg, bg);
    end else if (pick < 65) begin
      send_item(MODE_PUT, ch, r, c, fg, bg);
    end else if (pick < 76) begin
      // mostly legal targets; a fifth keep the raw bytes, nearly all out of range
      if ($urandom_range(4) != 0) begin
        r = 8'($urandom_range(ROWS - 1));
        c = 8'($urandom_range(COLUMNS - 1));
      end
      send_item(MODE_SET_CURSOR, ch, r, c, fg, bg);
    end else if (pick < 78) begin
      send_item(MODE_CLEAR, ch, r, c, fg, bg);
    end else if (pick < 84) begin
      send_item(MODE_SET_COLORS, ch, r, c, fg, bg);
    end else if (pick < 98) begin
      // favor the bottom rows, where text lands and scrolls
      if ($urandom_range(9) != 0) begin
        r = $urandom_range(1) ? 8'($urandom_range(ROWS - 1, WORK_ROWS - 4))
                              : 8'($urandom_range(ROWS - 1));
        c = 8'($urandom_range(COLUMNS - 1));
      end
      send_item(MODE_READ, ch, r, c, fg, bg);
    end else begin
      send_item(3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)), ch, r, c, fg, bg);
    end
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    mode       <= MODE_PUT;
    character  <= '0;
    row        <= '0;
    column     <= '0;
    foreground <= '0;
    background <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_item(MODE_READ, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_READ, 8'd255, 8'd255, 8'd255, 4'd15, 4'd15);
    send_item(MODE_SET_COLORS, 8'd0, 8'd0, 8'd0, 4'd15, 4'd15);
    send_item(MODE_PUT, "A", 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_PUT, CH_FIRST, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_PUT, CH_DELETE - 8'd1, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_PUT, CH_BACKSPACE, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_SET_CURSOR, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_PUT, CH_BACKSPACE, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_PUT, CH_TAB, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_PUT, CH_NEWLINE, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_PUT, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_PUT, CH_DELETE, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_PUT, 8'd255, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_PUT, CH_FIRST - 8'd1, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_SET_CURSOR, 8'd0, 8'(ROWS), 8'd0, 4'd0, 4'd0);
    send_item(MODE_SET_CURSOR, 8'd0, 8'd0, 8'(COLUMNS), 4'd0, 4'd0);
    // status row write, then wrap off it into a scroll
    send_item(MODE_SET_CURSOR, 8'd0, 8'(ROWS - 1), 8'(COLUMNS - 1), 4'd0, 4'd0);
    send_item(MODE_PUT, "Z", 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_READ, 8'd0, 8'(ROWS - 1), 8'(COLUMNS - 1), 4'd0, 4'd0);
    send_item(MODE_SET_CURSOR, 8'd0, 8'(WORK_ROWS - 1), 8'(COLUMNS - 2), 4'd0, 4'd0);
    send_item(MODE_PUT, CH_TAB, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_READ, 8'd0, 8'(WORK_ROWS - 2), 8'd0, 4'd0, 4'd0);
    send_item(MODE_CLEAR, 8'd0, 8'd0, 8'd0, 4'd0, 4'd15);
    send_item(MODE_READ, 8'd0, 8'(ROWS - 1), 8'(COLUMNS - 1), 4'd0, 4'd0);
    send_item(MODE_SPARE_HI, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0);
    send_item(MODE_CLEAR, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      no_idle = (phase == 1 || phase == 3);
      repeat (RANDOM_ITEMS / PHASES) send_random_item();
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    // let the checker record the last accepted beat before polling the count
    @(posedge clk);
    wait (reports_due == 0);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tccs_pkg.sv
design/tccs_ctrl.sv
design/tccs_dp.sv
design/text_console_cursor_scroll.sv
dv/console_checker.sv
dv/testbench.sv
